// ===== design/dfa_pkg.sv =====
// Shared types and constants for the double-ended frame allocator.
// No dependencies; imported by double_ended_frame_allocator_top.
`timescale 1ns / 1ps

package dfa_pkg;

    // Field widths
    localparam int ADDR_W   = 32;
    localparam int SIZE_W   = 21;
    localparam int OFF_W    = 22;   // pool offsets, up to 2^21 after rounding
    localparam int TOP_W    = 33;   // aligned base, may reach 2^32
    localparam int ALIGN_W  = 3;
    localparam int MASK_W   = 7;    // alignment mask, at most 63
    localparam int IDX_W    = 2;

    localparam int SIZE_BITS_DEF = 20;
    localparam logic [ALIGN_W-1:0] ALIGN_MAX = 3'd6;

    // Reset values of the configuration registers
    localparam logic [ADDR_W-1:0]  POOL_BASE_RST  = 32'd0;
    localparam logic [SIZE_W-1:0]  POOL_SIZE_RST  = 21'd1048576;
    localparam logic [ALIGN_W-1:0] ALIGN_LOG2_RST = 3'd4;

    // Configuration register indexes
    localparam logic [IDX_W-1:0] REG_POOL_BASE  = 2'd0;
    localparam logic [IDX_W-1:0] REG_POOL_SIZE  = 2'd1;
    localparam logic [IDX_W-1:0] REG_ALIGN_LOG2 = 2'd2;

    typedef enum logic [1:0] {
        CMD_ALLOC   = 2'd0,
        CMD_MARKER  = 2'd1,
        CMD_RELEASE = 2'd2
    } cmd_t;

    // One result item
    typedef struct packed {
        logic [SIZE_W-1:0] remaining_bytes;
        logic [SIZE_W-1:0] allocated_bytes;
        logic [ADDR_W-1:0] address;
        logic              status;
    } res_t;

    // Mask of the low bits cleared by the alignment
    function automatic logic [MASK_W-1:0] align_mask(logic [ALIGN_W-1:0] a);
        logic [ALIGN_W-1:0] e;
        e = (a > ALIGN_MAX) ? ALIGN_MAX : a;
        return MASK_W'((8'd1 << e) - 8'd1);
    endfunction

    // Round a byte count up to the alignment
    function automatic logic [OFF_W-1:0] round_size(logic [SIZE_W-1:0] v,
                                                   logic [MASK_W-1:0] m);
        logic [OFF_W-1:0] s;
        s = {1'b0, v} + {{(OFF_W-MASK_W){1'b0}}, m};
        return s & ~{{(OFF_W-MASK_W){1'b0}}, m};
    endfunction

endpackage

// ===== design/double_ended_frame_allocator_top.sv =====
// Double-ended frame allocator: one pool, low end grows up, high end down.
// Depends on dfa_pkg (types, widths, rounding helpers).
`timescale 1ns / 1ps

// Every input item (allocate, get marker, release) is handled combinationally:
// the tops are updated at the edge that accepts the item and its single result
// item is registered in the output register, or in the skid register while a
// result waits, so an item can be accepted every cycle while the skid register
// is empty. A two-deep output stage (output register plus skid register) lets
// one more item in while a result waits. Tops are offsets from the aligned base.
// A write to registers 0-2 (taken every cycle) restores both tops to the pool ends.
module double_ended_frame_allocator_top
    import dfa_pkg::*;
#(
    parameter int SIZE_BITS = SIZE_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // input items
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [63:0]          s_tdata,   // alloc_size[20:0], marker[52:21],
                                            // marker_valid[53], zero fill
    input  logic [2:0]           s_tuser,   // cmd[1:0], side[2]
    // result items
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [79:0]          m_tdata,   // address[31:0], allocated_bytes[52:32],
                                            // remaining_bytes[73:53], zero fill
    output logic [0:0]           m_tuser,   // status[0]
    // configuration writes
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [IDX_W-1:0]     cfg_index,
    input  logic [ADDR_W-1:0]    cfg_data
);

    localparam logic [TOP_W-1:0] SIZE_LIM = TOP_W'(1) << SIZE_BITS;

    // Configuration registers and derived pool geometry
    logic [ADDR_W-1:0]  pool_base_reg, pool_base_next;
    logic [SIZE_W-1:0]  pool_size_reg, pool_size_next;
    logic [ALIGN_W-1:0] align_reg, align_next;
    logic [TOP_W-1:0]   base_eff_reg, base_eff_next;
    logic [OFF_W-1:0]   size_eff_reg, size_eff_next;
    logic [MASK_W-1:0]  amask_reg, amask_next;
    logic               restore;
    logic [SIZE_W-1:0]  size_capped;
    logic [TOP_W-1:0]   base_sum;

    // Tops as offsets from the aligned base
    logic [OFF_W-1:0]   low_off_reg, low_off_next;
    logic [OFF_W-1:0]   high_off_reg, high_off_next;

    // Output stage
    logic               out_valid_reg, skid_valid_reg;
    res_t               out_reg, skid_reg;
    res_t               res;

    // Item decode
    cmd_t               cmd;
    logic               side;
    logic [SIZE_W-1:0]  alloc_size;
    logic [ADDR_W-1:0]  marker;
    logic               marker_valid;
    logic               s_accept, m_pop, cfg_accept;

    logic [OFF_W-1:0]   t_size, rem_cur, low_clamp, high_clamp, addr_off;
    logic [OFF_W-1:0]   used_off, rem_off;
    logic [TOP_W:0]     moff;
    logic               mneg, oom, addr_en;
    logic [TOP_W-1:0]   addr_sum;

    assign cmd          = cmd_t'(s_tuser[1:0]);
    assign side         = s_tuser[2];
    assign alloc_size   = s_tdata[20:0];
    assign marker       = s_tdata[52:21];
    assign marker_valid = s_tdata[53];

    assign cfg_ready  = 1'b1;
    assign cfg_accept = cfg_valid && cfg_ready;
    assign s_tready   = !skid_valid_reg;
    assign s_accept   = s_tvalid && s_tready;
    assign m_pop      = out_valid_reg && m_tready;

    // Configuration next values; reset loads the reset values
    always_comb begin
        pool_base_next = pool_base_reg;
        pool_size_next = pool_size_reg;
        align_next     = align_reg;
        restore        = 1'b0;
        if (!aresetn) begin
            pool_base_next = POOL_BASE_RST;
            pool_size_next = POOL_SIZE_RST;
            align_next     = ALIGN_LOG2_RST;
            restore        = 1'b1;
        end else if (cfg_accept) begin
            case (cfg_index)
                REG_POOL_BASE: begin
                    pool_base_next = cfg_data;
                    restore        = 1'b1;
                end
                REG_POOL_SIZE: begin
                    pool_size_next = cfg_data[SIZE_W-1:0];
                    restore        = 1'b1;
                end
                REG_ALIGN_LOG2: begin
                    align_next = cfg_data[ALIGN_W-1:0];
                    restore    = 1'b1;
                end
                default: restore = 1'b0;
            endcase
        end
    end

    // Aligned base and aligned, capped pool size
    always_comb begin
        amask_next  = align_mask(align_next);
        base_sum    = {1'b0, pool_base_next} + {{(TOP_W-MASK_W){1'b0}}, amask_next};
        base_eff_next = base_sum & ~{{(TOP_W-MASK_W){1'b0}}, amask_next};
        size_capped = ({{(TOP_W-SIZE_W){1'b0}}, pool_size_next} > SIZE_LIM)
                    ? SIZE_W'(SIZE_LIM) : pool_size_next;
        size_eff_next = round_size(size_capped, amask_next);
    end

    // Item step
    always_comb begin
        t_size  = round_size(alloc_size, amask_reg);
        rem_cur = high_off_reg - low_off_reg;
        oom     = t_size > rem_cur;

        // marker as an offset from the base, negative below it
        moff = {2'b0, marker} - {1'b0, base_eff_reg};
        mneg = moff[TOP_W];

        if (mneg)
            low_clamp = '0;
        else if (moff > {{(TOP_W+1-OFF_W){1'b0}}, high_off_reg})
            low_clamp = high_off_reg;
        else
            low_clamp = moff[OFF_W-1:0];

        if (mneg || (moff < {{(TOP_W+1-OFF_W){1'b0}}, low_off_reg}))
            high_clamp = low_off_reg;
        else if (moff > {{(TOP_W+1-OFF_W){1'b0}}, size_eff_reg})
            high_clamp = size_eff_reg;
        else
            high_clamp = moff[OFF_W-1:0];

        low_off_next  = low_off_reg;
        high_off_next = high_off_reg;
        addr_off      = low_off_reg;
        addr_en       = 1'b0;
        res.status    = 1'b0;

        case (cmd)
            CMD_ALLOC: begin
                if (oom) begin
                    res.status = 1'b1;
                end else if (!side) begin
                    addr_en      = 1'b1;
                    addr_off     = low_off_reg;
                    low_off_next = low_off_reg + t_size;
                end else begin
                    addr_en       = 1'b1;
                    high_off_next = high_off_reg - t_size;
                    addr_off      = high_off_next;
                end
            end
            CMD_MARKER: begin
                addr_en  = 1'b1;
                addr_off = side ? high_off_reg : low_off_reg;
            end
            CMD_RELEASE: begin
                if (marker_valid) begin
                    if (!side) low_off_next  = low_clamp;
                    else       high_off_next = high_clamp;
                end
            end
            default: addr_en = 1'b0;
        endcase

        addr_sum    = base_eff_reg + {{(TOP_W-OFF_W){1'b0}}, addr_off};
        res.address = addr_en ? addr_sum[ADDR_W-1:0] : '0;

        used_off = low_off_next + (size_eff_reg - high_off_next);
        rem_off  = high_off_next - low_off_next;
        res.allocated_bytes = used_off[SIZE_W-1:0];
        res.remaining_bytes = rem_off[SIZE_W-1:0];
    end

    // Configuration and top registers
    always_ff @(posedge aclk) begin
        pool_base_reg <= pool_base_next;
        pool_size_reg <= pool_size_next;
        align_reg     <= align_next;
        if (restore) begin
            base_eff_reg <= base_eff_next;
            size_eff_reg <= size_eff_next;
            amask_reg    <= amask_next;
            low_off_reg  <= '0;
            high_off_reg <= size_eff_next;
        end else if (s_accept) begin
            low_off_reg  <= low_off_next;
            high_off_reg <= high_off_next;
        end
    end

    // Output register with skid register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (m_pop) begin
            if (skid_valid_reg) begin
                out_reg        <= skid_reg;
                skid_valid_reg <= 1'b0;
            end else if (s_accept) begin
                out_reg <= res;
            end else begin
                out_valid_reg <= 1'b0;
            end
        end else if (s_accept) begin
            if (!out_valid_reg) begin
                out_reg       <= res;
                out_valid_reg <= 1'b1;
            end else begin
                skid_reg       <= res;
                skid_valid_reg <= 1'b1;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, out_reg.remaining_bytes, out_reg.allocated_bytes,
                       out_reg.address};
    assign m_tuser  = out_reg.status;

    // Checks
    a_skid_needs_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register holds an item while output register is empty");

    a_tops_ordered: assert property (@(posedge aclk) disable iff (!aresetn)
        (low_off_reg <= high_off_reg) && (high_off_reg <= size_eff_reg))
        else $error("pool tops out of order");

    a_oom_addr_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (m_tdata[31:0] == 32'd0))
        else $error("out-of-memory result carries an address");

    a_oom_keeps_tops: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && !cfg_accept && (cmd == CMD_ALLOC) && oom) |=>
        ($stable(low_off_reg) && $stable(high_off_reg)))
        else $error("out-of-memory allocate moved a top");

endmodule
